FILE: hw/rtl/kect_pkg.sv
// Shared types and constants for the keypad countdown timer.
package kect_pkg;

  localparam logic [4:0]  KEY_ENTER = 5'd16;
  localparam logic [4:0]  KEY_CLEAR = 5'd13;
  localparam logic [4:0]  KEY_DIGIT_MAX = 5'd9;
  localparam logic [11:0] TICKS_RESET = 12'd1000;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ENTER,
    CMD_CLEAR,
    CMD_DIGIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] digit;
  } cmd_t;

endpackage

FILE: hw/rtl/kect_front.sv
// Front end: accepts poll words and classifies the key into a command.
module kect_front
  import kect_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [4:0] key_code, [7:5] zero
  input  logic [0:0] s_tuser,   // [0] key_valid
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [4:0] key;

  assign key      = s_tdata[4:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.kind  = CMD_NONE;
    q_cmd.digit = key[3:0];
    if (s_tuser[0]) begin
      if (key == KEY_ENTER) begin
        q_cmd.kind = CMD_ENTER;
      end else if (key == KEY_CLEAR) begin
        q_cmd.kind = CMD_CLEAR;
      end else if (key != 5'd0 && key <= KEY_DIGIT_MAX) begin
        q_cmd.kind = CMD_DIGIT;
      end
    end
  end

endmodule

FILE: hw/rtl/kect_queue.sv
// Short command queue between the front end and the execution back end.
module kect_queue
  import kect_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full     = (count == DepthCnt);
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) full |-> !push;
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("queue pushed while full");

endmodule

FILE: hw/rtl/kect_back.sv
// Back end: carries out commands on the timer state and registers the result.
module kect_back
  import kect_pkg::*;
#(
  parameter int MAX_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data,
  input  logic        q_nonempty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);

  localparam logic [2:0] MaxCnt = 3'(MAX_DIGITS);

  logic [11:0] ticks_per_unit;
  logic        entry_mode, entry_mode_next;
  logic [13:0] entry_value, entry_value_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [25:0] countdown, countdown_next;
  logic        led_active, led_active_next;

  logic        exec;
  logic [25:0] product;
  logic [17:0] shifted;
  logic [25:0] cd_load;
  logic        la_load;

  assign exec    = q_nonempty && (!m_tvalid || m_tready);
  assign q_pop   = exec;
  // widen both operands so the full 26-bit product is kept
  assign product = {12'd0, entry_value} * {14'd0, ticks_per_unit};
  assign shifted = {1'b0, entry_value, 3'b000} + {3'b000, entry_value, 1'b0}
                 + {14'd0, q_head.digit};

  always_comb begin
    entry_mode_next  = entry_mode;
    entry_value_next = entry_value;
    digit_count_next = digit_count;
    cd_load          = countdown;
    la_load          = led_active;
    case (q_head.kind)
      CMD_ENTER: begin
        if (!entry_mode) begin
          entry_mode_next = 1'b1;
        end else begin
          entry_mode_next  = 1'b0;
          entry_value_next = '0;
          digit_count_next = '0;
          if (entry_value != '0) begin
            cd_load = product;
            la_load = 1'b1;
          end else begin
            cd_load = '0;
          end
        end
      end
      CMD_CLEAR: begin
        if (!entry_mode) begin
          cd_load          = '0;
          entry_value_next = '0;
          digit_count_next = '0;
        end
      end
      CMD_DIGIT: begin
        if (entry_mode) begin
          if (digit_count >= MaxCnt) begin
            // restart the entry, dropping this digit
            entry_value_next = '0;
            digit_count_next = '0;
          end else begin
            entry_value_next = shifted[13:0];
            digit_count_next = digit_count + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    countdown_next  = (la_load && cd_load != '0) ? cd_load - 1'b1 : cd_load;
    led_active_next = (countdown_next == '0) ? 1'b0 : la_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TICKS_RESET;
    end else if (cfg_we) begin
      ticks_per_unit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_mode  <= 1'b0;
      entry_value <= '0;
      digit_count <= '0;
      countdown   <= '0;
      led_active  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (exec) begin
        entry_mode  <= entry_mode_next;
        entry_value <= entry_value_next;
        digit_count <= digit_count_next;
        countdown   <= countdown_next;
        led_active  <= led_active_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      m_tdata <= {1'b0, digit_count_next, entry_mode_next, countdown_next,
                  led_active_next};
    end
  end

  property p_count_needs_led;
    @(posedge clk) disable iff (rst) (countdown != '0) |-> led_active;
  endproperty
  a_count_needs_led: assert property (p_count_needs_led)
    else $error("countdown running with LED off");

  property p_digits_bounded;
    @(posedge clk) disable iff (rst) digit_count <= MaxCnt;
  endproperty
  a_digits_bounded: assert property (p_digits_bounded)
    else $error("digit count beyond limit");

  property p_idle_no_digits;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tdata[27]) |-> (m_tdata[30:28] == 3'd0);
  endproperty
  a_idle_no_digits: assert property (p_idle_no_digits)
    else $error("digits reported outside entry mode");

endmodule

FILE: hw/rtl/keypad_entered_countdown_timer.sv
// Top level of the keypad-entered countdown timer.
//
// One poll word enters on the s_ channel per tick: s_tuser[0] flags a key
// press and s_tdata[4:0] carries the decoded key code. Keys 16 open and close
// digit entry, 1 to 9 append digits, 13 clears the countdown when idle.
// Each poll word yields exactly one result word on the m_ channel with the
// LED drive, the remaining ticks, the entry flag and the digit count.
// The cfg channel writes ticks_per_unit (12 bits); it is always ready.
//
// A poll word accepted on s_ is written into the queue, executed from the
// queue head by the back end and offered on m_ from its result register.
// Throughput is one word per cycle while m_tready does not stall the back end,
// which computes its state update (multiply, then decrement and zero test) combinationally.
// Reset clears the timer, the entry and the queue, and sets ticks_per_unit
// to 1000. When m_tready is low the result holds, the back end stops and the
// two-entry queue fills; s_tready drops only once the queue is full.
module keypad_entered_countdown_timer
  import kect_pkg::*;
#(
  parameter int MAX_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] key_code, [7:5] zero
  input  logic [0:0]  s_tuser,   // [0] key_valid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] led_drive, [26:1] remaining_ticks,
                                 // [27] entering, [30:28] digits_entered,
                                 // [31] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data   // [11:0] ticks_per_unit
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_nonempty;
  cmd_t q_head;

  assign cfg_ready = 1'b1;

  kect_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  kect_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  kect_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

FILE: test/keypad_entered_countdown_timer_tb.sv
// Self-checking testbench for the keypad-entered countdown timer.
`timescale 1ns / 100ps

module keypad_entered_countdown_timer_tb;
  import kect_pkg::*;

  localparam int         DIGITS_MAX    = 4;
  localparam int         STALL_LIMIT   = 1000;
  localparam int         REPORT_CAP    = 30;
  localparam logic [4:0] KEY_NONE      = 5'd0;
  localparam logic [4:0] KEY_DIGIT_MIN = 5'd1;
  localparam logic [4:0] KEY_CODE_MAX  = 5'd31;

  typedef struct packed {
    logic       pressed;
    logic [4:0] code;
  } poll_t;

  // Same layout as m_tdata[30:0], led_drive at bit 0.
  typedef struct packed {
    logic [2:0]  digits;
    logic        entering;
    logic [25:0] remaining;
    logic        led;
  } timer_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [4:0] key_code, [7:5] zero
  logic [0:0]  s_tuser = '0;   // [0] key_valid
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [0] led, [26:1] remaining, [27] entering, [30:28] digits
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;  // [11:0] ticks_per_unit

  keypad_entered_countdown_timer #(.MAX_DIGITS(DIGITS_MAX)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Timer state as the block should hold it.
  logic [11:0] unit_ticks   = TICKS_RESET;
  logic        in_entry     = 1'b0;
  logic [13:0] typed_value  = '0;
  logic [2:0]  typed_digits = '0;
  logic [25:0] ticks_left   = '0;
  logic        lamp_on      = 1'b0;

  poll_t       poll_q[$];
  timer_word_t pending_words[$];
  poll_t       on_bus;
  logic        drv_busy;
  int          gap_left = 0;
  int          stall_left = 0;
  logic        steady = 1'b0;
  int          polls_queued = 0;
  int          polls_accepted = 0;
  int          words_checked = 0;
  int          errors = 0;
  int          loads = 0;
  int          turn_offs = 0;
  int          settings_used = 1;
  int          idle_cycles = 0;

  function automatic timer_word_t timer_advance(input logic pressed, input logic [4:0] code);
    timer_word_t w;
    logic        was_lit;
    was_lit = lamp_on;
    if (pressed) begin
      if (!in_entry) begin
        if (code == KEY_ENTER) begin
          in_entry = 1'b1;
        end else if (code == KEY_CLEAR) begin
          ticks_left   = '0;
          typed_value  = '0;
          typed_digits = '0;
        end
      end else if (code == KEY_ENTER) begin
        in_entry = 1'b0;
        if (typed_value != 0) begin
          ticks_left = typed_value * unit_ticks;
          lamp_on    = 1'b1;
          loads++;
        end else begin
          ticks_left = '0;
        end
        typed_value  = '0;
        typed_digits = '0;
      end else if (code >= KEY_DIGIT_MIN && code <= KEY_DIGIT_MAX) begin
        // a digit past the limit throws the whole entry away
        if (typed_digits >= DIGITS_MAX) begin
          typed_value  = '0;
          typed_digits = '0;
        end else begin
          typed_value  = typed_value * 10 + code;
          typed_digits = typed_digits + 3'd1;
        end
      end
    end
    if (lamp_on && ticks_left != 0) ticks_left = ticks_left - 26'd1;
    if (ticks_left == 0) lamp_on = 1'b0;
    if (was_lit && !lamp_on) turn_offs++;
    w.led       = lamp_on;
    w.remaining = ticks_left;
    w.entering  = in_entry;
    w.digits    = typed_digits;
    return w;
  endfunction

  // Driver: one poll word per handshake, random gap between words unless steady is set.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      drv_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        pending_words.push_back(timer_advance(on_bus.pressed, on_bus.code));
        polls_accepted++;
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (poll_q.size() > 0) begin
          on_bus = poll_q.pop_front();
          s_tdata <= {3'b000, on_bus.code};
          s_tuser <= on_bus.pressed;
          drv_busy = 1'b1;
          gap_left = steady ? 0 : $urandom_range(0, 5);
        end
      end
      s_tvalid <= drv_busy;
    end
  end

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk) begin
    timer_word_t want;
    timer_word_t got;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[30:0];
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
        end else begin
          want = pending_words.pop_front();
          compare_field("led_drive", want.led, got.led);
          compare_field("remaining_ticks", want.remaining, got.remaining);
          compare_field("entering", want.entering, got.entering);
          compare_field("digits_entered", want.digits, got.digits);
        end
        words_checked++;
        stall_left = steady ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0);
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_poll(input logic pressed, input logic [4:0] code);
    poll_t p;
    p.pressed = pressed;
    p.code    = code;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  task automatic key(input logic [4:0] code);
    push_poll(1'b1, code);
  endtask

  task automatic quiet_polls(input int n);
    repeat (n) push_poll(1'b0, 5'($urandom_range(0, KEY_CODE_MAX)));
  endtask

  task automatic any_digit();
    key(5'($urandom_range(KEY_DIGIT_MIN, KEY_DIGIT_MAX)));
  endtask

  task automatic wait_drained();
    while (polls_accepted != polls_queued || pending_words.size() != 0) @(posedge clk);
  endtask

  // Write ticks_per_unit once every result is in.
  task automatic write_ticks(input logic [11:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    unit_ticks = value;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic typed_entry(input int ndigits, input logic spread);
    key(KEY_ENTER);
    for (int i = 0; i < ndigits; i++) begin
      if (spread && $urandom_range(0, 3) == 0) quiet_polls($urandom_range(1, 2));
      if (spread && $urandom_range(0, 9) == 0) key(5'($urandom_range(10, KEY_CODE_MAX)));
      any_digit();
    end
    key(KEY_ENTER);
  endtask

  task automatic random_polls(input int target);
    int   first;
    int   r;
    int   n;
    logic short_units;
    first = polls_queued;
    short_units = (unit_ticks <= 12'd8);
    while (polls_queued - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(DIGITS_MAX + 1, DIGITS_MAX + 2);
        else n = short_units ? $urandom_range(1, 2) : $urandom_range(1, DIGITS_MAX);
        typed_entry(n, 1'b1);
      end else if (r < 70) begin
        quiet_polls($urandom_range(1, short_units ? 24 : 6));
      end else if (r < 78) begin
        key(KEY_CLEAR);
      end else if (r < 90) begin
        key(5'($urandom_range(0, KEY_CODE_MAX)));
      end else begin
        // open an entry and leave it hanging
        key(KEY_ENTER);
        repeat ($urandom_range(0, 3)) any_digit();
      end
    end
  endtask

  int plan[8] = '{1, 4095, 0, 1000, -1, 1, -1, 3};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part, starting at the reset setting
    push_poll(1'b0, KEY_NONE);
    push_poll(1'b0, KEY_ENTER);
    key(KEY_CLEAR);
    key(KEY_ENTER);
    repeat (DIGITS_MAX) key(KEY_DIGIT_MAX);
    key(5'd5);
    key(KEY_ENTER);
    key(KEY_ENTER);
    key(5'd10);
    key(KEY_CLEAR);
    key(KEY_CODE_MAX);
    key(KEY_NONE);
    key(5'd7);
    key(KEY_ENTER);
    key(KEY_CLEAR);
    write_ticks(12'd4095);
    key(KEY_ENTER);
    repeat (DIGITS_MAX) key(KEY_DIGIT_MAX);
    key(KEY_ENTER);
    key(KEY_CLEAR);
    write_ticks(12'd0);
    typed_entry(1, 1'b0);
    write_ticks(12'd1);
    typed_entry(1, 1'b0);
    quiet_polls(3);

    foreach (plan[i]) begin
      write_ticks(plan[i] < 0 ? 12'($urandom_range(1, 4095)) : 12'(plan[i]));
      steady = (i == 3 || i == 6);
      random_polls(135);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d result words across %0d tick settings.", words_checked,
             settings_used);
    $display("Timer loaded %0d times and went dark %0d times; %0d mismatches.", loads,
             turn_offs, errors);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
